// ----- rtl/gfsr4_pkg.sv -----
// ----------------------------------------------------------------------------
// gfsr4_pkg
// Shared types and constants of the four-tap GFSR generator.
// ----------------------------------------------------------------------------
package gfsr4_pkg;

  localparam int unsigned TableDepth = 16384;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned WordW      = 32;
  localparam int unsigned SeedW      = 64;

  localparam logic [AddrW-1:0] LagA      = AddrW'(471);
  localparam logic [AddrW-1:0] LagB      = AddrW'(1586);
  localparam logic [AddrW-1:0] LagC      = AddrW'(6988);
  localparam logic [AddrW-1:0] LagD      = AddrW'(9689);
  localparam logic [AddrW-1:0] PosReset  = AddrW'(32);

  localparam logic [WordW-1:0] LcgMult   = 32'd69069;
  localparam logic [WordW-1:0] ZeroSeed  = 32'd4357;

  // Forced-bit words sit at 7, 10, 13, ... (32 of them).
  localparam logic [6:0]       ForceBase = 7'd7;
  localparam logic [6:0]       ForceStep = 7'd3;

  // Operation codes of an input item.
  localparam logic OpGet  = 1'b0;
  localparam logic OpSeed = 1'b1;

  typedef enum logic [1:0] {
    LAG_SEL_A,
    LAG_SEL_B,
    LAG_SEL_C,
    LAG_SEL_D
  } lag_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     start_get;   // advance position
    logic     start_seed;  // load generator state, restart fill
    logic     seed_step;   // one generator step, write word every 32 steps
    logic     rd_en;       // read one lag word
    lag_sel_e lag_sel;
    logic     acc_first;   // load accumulator from read data
    logic     acc_xor;     // fold read data into accumulator
    logic     wr_get;      // store result at position, load output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic seed_last;       // current step writes the last table word
  } status_t;

endpackage

// ----- rtl/four_tap_gfsr_generator_top.sv -----
// ----------------------------------------------------------------------------
// four_tap_gfsr_generator_top
// Four-tap GFSR random word generator over a 16384-word lag table.
// ----------------------------------------------------------------------------
// A get item (operation 0) passes through four lag-read states and a
// result-write state: the single-port lag table serves four lag reads and
// one result write, one access per cycle, and the write state holds while
// the output register is stalled. Its result is loaded into the output
// register in the write state and waits there while the next item is taken.
// A reseed item (operation 1) runs the 32-bit LCG one step per cycle and
// writes one table word every 32 steps until all 16384 words are written;
// it gives no result. The forced diagonal bits are applied as the words are
// written, with no extra pass. Table contents are undefined until the first
// reseed, so a get before it returns arbitrary data.
// ----------------------------------------------------------------------------
module four_tap_gfsr_generator_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [gfsr4_pkg::SeedW-1:0] seed_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [gfsr4_pkg::WordW-1:0] random_value_o
);

  gfsr4_pkg::cmd_t    cmd;
  gfsr4_pkg::status_t status;

  // Sequence each item and track the output register.
  gfsr4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Hold the table, the generator state and the result.
  gfsr4_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .seed_value_i   (seed_value_i),
    .random_value_o (random_value_o)
  );

  // Never overwrite a result that is still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_get |-> !(out_valid_o && out_stall_i))
    else $error("result written while output register is stalled");

  // A started get reads the first lag in the following cycle.
  a_get_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start_get |=> (cmd.rd_en && (cmd.lag_sel == gfsr4_pkg::LAG_SEL_A)))
    else $error("get did not begin with the first lag read");

  // The fill owns the memory port alone.
  a_fill_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.seed_step |-> !(cmd.rd_en || cmd.wr_get || cmd.start_get))
    else $error("memory port conflict during table fill");

  // A result becomes valid only through a result write.
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.wr_get))
    else $error("output valid raised without a result write");

endmodule

// ----- rtl/gfsr4_datapath.sv -----
// ----------------------------------------------------------------------------
// gfsr4_datapath
// Lag table memory, LCG fill logic, position and result accumulator.
// ----------------------------------------------------------------------------
module gfsr4_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gfsr4_pkg::cmd_t                     cmd_i,
  output gfsr4_pkg::status_t                  status_o,
  input  logic [gfsr4_pkg::SeedW-1:0]         seed_value_i,
  output logic [gfsr4_pkg::WordW-1:0]         random_value_o
);

  localparam int unsigned AW = gfsr4_pkg::AddrW;
  localparam int unsigned WW = gfsr4_pkg::WordW;

  logic [WW-1:0] mem [gfsr4_pkg::TableDepth];
  logic [WW-1:0] rdata_q;

  logic [AW-1:0] pos_q, pos_d;
  logic [WW-1:0] x_q, x_d;
  logic [WW-1:0] word_q, word_d;
  logic [4:0]    bit_cnt_q, bit_cnt_d;
  logic [AW-1:0] fill_addr_q, fill_addr_d;
  logic [4:0]    frc_idx_q, frc_idx_d;
  logic          frc_act_q, frc_act_d;
  logic [6:0]    frc_tgt_q, frc_tgt_d;
  logic [WW-1:0] acc_q, acc_d;
  logic [WW-1:0] out_q, out_d;

  logic [WW-1:0] x_mul;
  logic [WW-1:0] word_next;
  logic [WW-1:0] fill_word;
  logic          frc_hit;
  logic          word_done;
  logic [AW-1:0] lag;
  logic [AW-1:0] mem_addr;
  logic [WW-1:0] mem_wdata;
  logic          mem_we;
  logic [WW-1:0] get_value;

  always_comb begin
    x_mul     = WW'(x_q * gfsr4_pkg::LcgMult);
    word_next = {word_q[WW-2:0], x_mul[WW-1]};
    word_done = (bit_cnt_q == 5'd31);
    frc_hit   = frc_act_q && ({{(AW-7){1'b0}}, frc_tgt_q} == fill_addr_q);
    fill_word = word_next;
    if (frc_hit) begin
      fill_word = (word_next & ({WW{1'b1}} >> frc_idx_q)) |
                  ({1'b1, {(WW-1){1'b0}}} >> frc_idx_q);
    end
    get_value = acc_q ^ rdata_q;
  end

  always_comb begin
    case (cmd_i.lag_sel)
      gfsr4_pkg::LAG_SEL_A: lag = gfsr4_pkg::LagA;
      gfsr4_pkg::LAG_SEL_B: lag = gfsr4_pkg::LagB;
      gfsr4_pkg::LAG_SEL_C: lag = gfsr4_pkg::LagC;
      gfsr4_pkg::LAG_SEL_D: lag = gfsr4_pkg::LagD;
      default:              lag = gfsr4_pkg::LagA;
    endcase
  end

  // Single memory port: fill write, lag read or result write.
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = fill_word;
    mem_addr  = pos_q - lag;
    if (cmd_i.seed_step) begin
      mem_addr = fill_addr_q;
      mem_we   = word_done;
    end else if (cmd_i.wr_get) begin
      mem_addr  = pos_q;
      mem_wdata = get_value;
      mem_we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[mem_addr];
    end
  end

  always_comb begin
    pos_d       = pos_q;
    x_d         = x_q;
    word_d      = word_q;
    bit_cnt_d   = bit_cnt_q;
    fill_addr_d = fill_addr_q;
    frc_idx_d   = frc_idx_q;
    frc_act_d   = frc_act_q;
    frc_tgt_d   = frc_tgt_q;
    acc_d       = acc_q;
    out_d       = out_q;

    if (cmd_i.start_seed) begin
      x_d         = (seed_value_i == '0) ? gfsr4_pkg::ZeroSeed : seed_value_i[WW-1:0];
      bit_cnt_d   = '0;
      fill_addr_d = '0;
      frc_idx_d   = '0;
      frc_act_d   = 1'b1;
      frc_tgt_d   = gfsr4_pkg::ForceBase;
      pos_d       = gfsr4_pkg::PosReset;
    end
    if (cmd_i.seed_step) begin
      x_d       = x_mul;
      word_d    = word_next;
      bit_cnt_d = bit_cnt_q + 5'd1;
      if (word_done) begin
        fill_addr_d = fill_addr_q + AW'(1);
        if (frc_hit) begin
          frc_idx_d = frc_idx_q + 5'd1;
          frc_tgt_d = frc_tgt_q + gfsr4_pkg::ForceStep;
          frc_act_d = (frc_idx_q != 5'd31);
        end
      end
    end
    if (cmd_i.start_get) begin
      pos_d = pos_q + AW'(1);
    end
    if (cmd_i.acc_first) begin
      acc_d = rdata_q;
    end else if (cmd_i.acc_xor) begin
      acc_d = acc_q ^ rdata_q;
    end
    if (cmd_i.wr_get) begin
      out_d = get_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= gfsr4_pkg::PosReset;
      bit_cnt_q   <= '0;
      fill_addr_q <= '0;
      frc_idx_q   <= '0;
      frc_act_q   <= 1'b0;
      frc_tgt_q   <= gfsr4_pkg::ForceBase;
    end else begin
      pos_q       <= pos_d;
      bit_cnt_q   <= bit_cnt_d;
      fill_addr_q <= fill_addr_d;
      frc_idx_q   <= frc_idx_d;
      frc_act_q   <= frc_act_d;
      frc_tgt_q   <= frc_tgt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    word_q <= word_d;
    acc_q  <= acc_d;
    out_q  <= out_d;
  end

  assign status_o.seed_last = word_done && (fill_addr_q == {AW{1'b1}});
  assign random_value_o     = out_q;

endmodule

// ----- rtl/gfsr4_ctrl.sv -----
// ----------------------------------------------------------------------------
// gfsr4_ctrl
// Sequencer for get and reseed items, and output valid tracking.
// ----------------------------------------------------------------------------
module gfsr4_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output gfsr4_pkg::cmd_t    cmd_o,
  input  gfsr4_pkg::status_t status_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_WR,
    ST_FILL
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   can_take;
  logic   take;

  assign out_free = !(out_valid_q && out_stall_i);

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    can_take   = 1'b0;

    case (state_q)
      ST_IDLE: can_take = 1'b1;
      ST_RD0: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.lag_sel = gfsr4_pkg::LAG_SEL_A;
        state_d       = ST_RD1;
      end
      ST_RD1: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.lag_sel   = gfsr4_pkg::LAG_SEL_B;
        cmd_o.acc_first = 1'b1;
        state_d         = ST_RD2;
      end
      ST_RD2: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.lag_sel = gfsr4_pkg::LAG_SEL_C;
        cmd_o.acc_xor = 1'b1;
        state_d       = ST_RD3;
      end
      ST_RD3: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.lag_sel = gfsr4_pkg::LAG_SEL_D;
        cmd_o.acc_xor = 1'b1;
        state_d       = ST_WR;
      end
      ST_WR: begin
        // Hold until the output register is free.
        if (out_free) begin
          cmd_o.wr_get = 1'b1;
          can_take     = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_FILL: begin
        cmd_o.seed_step = 1'b1;
        if (status_i.seed_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    take = can_take && in_valid_i;
    if (take) begin
      if (operation_i == gfsr4_pkg::OpSeed) begin
        cmd_o.start_seed = 1'b1;
        state_d          = ST_FILL;
      end else begin
        cmd_o.start_get = 1'b1;
        state_d         = ST_RD0;
      end
    end

    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.wr_get) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = !can_take;
  assign out_valid_o = out_valid_q;

endmodule
